[design/cpts_pkg.sv]
// Shared types, constants and helper functions of the task scheduler
package cpts_pkg;

  // default number of task slots
  localparam int unsigned TASK_SLOTS_DEF = 64;

  // reset contents of slot 0 and of the other slots
  localparam logic [7:0] SLOT0_COUNTER  = 8'd15;
  localparam logic [6:0] SLOT0_PRIORITY = 7'd15;
  localparam logic [6:0] SLOTN_PRIORITY = 7'd1;

  // command codes of an input item
  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_SCHED = 2'd1,
    CMD_WRITE = 2'd2,
    CMD_READ  = 2'd3
  } cmd_e;

  // input item
  typedef struct packed {
    logic [1:0] cmd;
    logic       user_mode;
    logic [5:0] task_index;
    logic       entry_valid;
    logic       entry_runnable;
    logic [6:0] entry_priority;
    logic [7:0] entry_counter;
  } cpts_in_t;

  // result item
  typedef struct packed {
    logic        switched;
    logic [5:0]  current_task;
    logic        read_valid;
    logic        read_runnable;
    logic [6:0]  read_priority;
    logic [7:0]  read_counter;
    logic [31:0] read_user_ticks;
    logic [31:0] read_kernel_ticks;
  } cpts_out_t;

  // one word of the task table memory
  typedef struct packed {
    logic [6:0]  prio;
    logic [7:0]  counter;
    logic [31:0] user_ticks;
    logic [31:0] kernel_ticks;
  } cpts_entry_t;

  localparam int unsigned ENTRY_W = $bits(cpts_entry_t);

  // commands from the controller to the datapath
  typedef struct packed {
    logic cap;          // take the input item
    logic item_rd;      // read the table at the item address
    logic item_wr;      // write a task entry
    logic rd_cap;       // latch the read fields
    logic tick_wb;      // write back the ticked entry
    logic sweep_start;  // begin a pass over the slots
    logic sweep_pass1;  // the pass also recomputes counters
    logic sweep_run;    // advance the pass
    logic commit;       // take the best slot as running task
    logic load_out;     // move the result into the output register
  } cpts_ctrl_t;

  // status from the datapath to the controller
  typedef struct packed {
    cmd_e cmd;
    logic sweep_done;
    logic zero_best;
    logic tick_sched;
    logic out_free;
  } cpts_stat_t;

  // table word as seen by the logic: a slot never written reads as its reset value
  function automatic cpts_entry_t entry_eff(logic is_slot0, logic written, cpts_entry_t raw);
    cpts_entry_t e;
    e = raw;
    if (!written) begin
      e.prio         = is_slot0 ? SLOT0_PRIORITY : SLOTN_PRIORITY;
      e.counter      = is_slot0 ? SLOT0_COUNTER : 8'd0;
      e.user_ticks   = 32'd0;
      e.kernel_ticks = 32'd0;
    end
    return e;
  endfunction

endpackage

[design/cpts_stream_if.sv]
// Valid/ready stream channel carrying one item payload
interface cpts_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

[design/counter_priority_task_scheduler_core.sv]
// Top level of the counter based priority task scheduler
//
//   channel | modport | handshake     | payload
//   in_i    | sink    | valid / ready | cpts_in_t: cmd, user_mode, task_index, entry fields
//   out_o   | source  | valid / ready | cpts_out_t: switched, current_task, read fields
//
// One item at a time. Read and plain tick do one table read; a write does none.
// A schedule sweeps slots TASK_SLOTS-1 down to 1, one slot a cycle, and sweeps
// them again to recompute the counters when the best counter found was zero.
// Reset is asynchronous and active low; the table needs no clearing pass.
// A waiting result sits in the output register while the next item is taken;
// that next item finishes only once the waiting result is taken.
module counter_priority_task_scheduler_core import cpts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input logic          clk_i,
  input logic          rst_ni,
  cpts_stream_if.sink   in_i,
  cpts_stream_if.source out_o
);
  cpts_ctrl_t ctrl;
  cpts_stat_t stat;
  logic       in_ready;

  cpts_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  cpts_datapath #(
    .TASK_SLOTS (TASK_SLOTS)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_payload_i  (in_i.payload),
    .out_payload_o (out_o.payload),
    .out_valid_o   (out_o.valid),
    .out_ready_i   (out_o.ready),
    .ctrl_i        (ctrl),
    .stat_o        (stat)
  );

  assign in_i.ready = in_ready;

  // a decision is taken only after the sweep has drained
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl.commit |-> stat.sweep_done)
    else $error("commit before sweep finished");

  // the recompute sweep starts only when the best counter was zero
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.sweep_start && ctrl.sweep_pass1) |-> stat.zero_best)
    else $error("recompute without zero best counter");

  // only one item is in work
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("second item taken while busy");

  // a loaded result shows on the output
  assert property (@(posedge clk_i) disable iff (!rst_ni) ctrl.load_out |=> out_o.valid)
    else $error("result lost at output register");
endmodule

[design/cpts_ram.sv]
// Generic simple dual-port RAM with registered read
module cpts_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                                   clk_i,
  input  logic                                   we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                       wdata_i,
  input  logic                                   re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                       rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

[design/cpts_ctrl.sv]
// Controller state machine of the task scheduler
module cpts_ctrl import cpts_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  cpts_stat_t stat_i,
  output cpts_ctrl_t ctrl_o
);
  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_RD_DATA  = 3'd2;
  localparam logic [2:0] S_SCAN     = 3'd3;
  localparam logic [2:0] S_RECALC   = 3'd4;
  localparam logic [2:0] S_FINISH   = 3'd5;

  logic [2:0] state_q, state_d;

  // next state and commands
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.cap = 1'b1;
          state_d    = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.cmd)
          CMD_WRITE: begin
            ctrl_o.item_wr = 1'b1;
            state_d        = S_FINISH;
          end
          CMD_SCHED: begin
            ctrl_o.sweep_start = 1'b1;
            state_d            = S_SCAN;
          end
          default: begin
            ctrl_o.item_rd = 1'b1;
            state_d        = S_RD_DATA;
          end
        endcase
      end
      S_RD_DATA: begin
        if (stat_i.cmd == CMD_READ) begin
          ctrl_o.rd_cap = 1'b1;
          state_d       = S_FINISH;
        end else begin
          ctrl_o.tick_wb = 1'b1;
          if (stat_i.tick_sched) begin
            ctrl_o.sweep_start = 1'b1;
            state_d            = S_SCAN;
          end else begin
            state_d = S_FINISH;
          end
        end
      end
      S_SCAN: begin
        ctrl_o.sweep_run = 1'b1;
        if (stat_i.sweep_done) begin
          if (stat_i.zero_best) begin
            ctrl_o.sweep_start = 1'b1;
            ctrl_o.sweep_pass1 = 1'b1;
            state_d            = S_RECALC;
          end else begin
            ctrl_o.commit = 1'b1;
            state_d       = S_FINISH;
          end
        end
      end
      S_RECALC: begin
        ctrl_o.sweep_run = 1'b1;
        if (stat_i.sweep_done) begin
          ctrl_o.commit = 1'b1;
          state_d       = S_FINISH;
        end
      end
      S_FINISH: begin
        if (stat_i.out_free) begin
          ctrl_o.load_out = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end
endmodule

[design/cpts_datapath.sv]
// Datapath of the task scheduler: task table, slot sweep, result registers
module cpts_datapath import cpts_pkg::*; #(
  parameter int unsigned TASK_SLOTS = TASK_SLOTS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  cpts_in_t   in_payload_i,
  output cpts_out_t  out_payload_o,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  input  cpts_ctrl_t ctrl_i,
  output cpts_stat_t stat_o
);
  localparam int unsigned IW = (TASK_SLOTS > 1) ? $clog2(TASK_SLOTS) : 1;
  localparam logic [IW-1:0] LAST_SLOT = IW'(TASK_SLOTS - 1);
  localparam logic [IW-1:0] FIRST_SCANNED = IW'(1);

  // item and task state
  cpts_in_t                req_q;
  logic [IW-1:0]           running_q, running_d;
  logic [TASK_SLOTS-1:0]   valid_q, valid_d;
  logic [TASK_SLOTS-1:0]   runnable_q, runnable_d;
  logic [TASK_SLOTS-1:0]   written_q, written_d;

  // sweep state
  logic [IW-1:0] sp_q, sp_d;
  logic          issue_en_q, issue_en_d;
  logic          pipe_vld_q, pipe_vld_d;
  logic [IW-1:0] pipe_idx_q, pipe_idx_d;
  logic          pass_q, pass_d;
  logic          best_found_q, best_found_d;
  logic [7:0]    best_cnt_q, best_cnt_d;
  logic [IW-1:0] best_idx_q, best_idx_d;

  // result and output registers
  cpts_out_t res_q, res_d;
  cpts_out_t out_q, out_d;
  logic      out_valid_q, out_valid_d;

  // table memory ports
  logic                ram_we, ram_re;
  logic [IW-1:0]       ram_waddr, ram_raddr;
  cpts_entry_t         ram_wdata;
  logic [ENTRY_W-1:0]  ram_rdata;

  // decoded item fields and table views
  cmd_e          cmd;
  logic          idx_ok;
  logic [IW-1:0] item_addr;
  cpts_entry_t   item_ent, pipe_ent, tick_ent;
  logic [7:0]    rc_cnt, cand_cnt;
  logic          cand, better;

  cpts_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (TASK_SLOTS)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // item decode and table word views
  always_comb begin
    cmd       = cmd_e'(req_q.cmd);
    idx_ok    = 32'(req_q.task_index) < TASK_SLOTS;
    item_addr = (cmd == CMD_TICK) ? running_q : IW'(req_q.task_index);
    item_ent  = entry_eff(item_addr == '0, written_q[item_addr], cpts_entry_t'(ram_rdata));
    pipe_ent  = entry_eff(pipe_idx_q == '0, written_q[pipe_idx_q], cpts_entry_t'(ram_rdata));
  end

  // tick update of the running task
  always_comb begin
    tick_ent = item_ent;
    if (req_q.user_mode) begin
      tick_ent.user_ticks = item_ent.user_ticks + 32'd1;
    end else begin
      tick_ent.kernel_ticks = item_ent.kernel_ticks + 32'd1;
    end
    tick_ent.counter = (item_ent.counter > 8'd1) ? (item_ent.counter - 8'd1) : 8'd0;
  end

  // sweep compare: recompute on the second pass, keep the first largest counter
  always_comb begin
    rc_cnt   = (pipe_ent.counter >> 1) + 8'(pipe_ent.prio);
    cand_cnt = pass_q ? rc_cnt : pipe_ent.counter;
    cand     = ctrl_i.sweep_run && pipe_vld_q && valid_q[pipe_idx_q] && runnable_q[pipe_idx_q];
    better   = cand && (!best_found_q || (cand_cnt > best_cnt_q));
  end

  // table memory access
  always_comb begin
    ram_re    = 1'b0;
    ram_raddr = item_addr;
    ram_we    = 1'b0;
    ram_waddr = item_addr;
    ram_wdata = tick_ent;
    if (ctrl_i.item_rd) begin
      ram_re = 1'b1;
    end else if (ctrl_i.sweep_run && issue_en_q) begin
      ram_re    = 1'b1;
      ram_raddr = sp_q;
    end
    if (ctrl_i.item_wr) begin
      ram_we                 = idx_ok;
      ram_wdata.prio         = req_q.entry_priority;
      ram_wdata.counter      = req_q.entry_counter;
      ram_wdata.user_ticks   = 32'd0;
      ram_wdata.kernel_ticks = 32'd0;
    end else if (ctrl_i.tick_wb) begin
      ram_we = 1'b1;
    end else if (ctrl_i.sweep_run && pipe_vld_q && pass_q) begin
      ram_we            = valid_q[pipe_idx_q];
      ram_waddr         = pipe_idx_q;
      ram_wdata         = pipe_ent;
      ram_wdata.counter = rc_cnt;
    end
  end

  // slot flags and running task
  always_comb begin
    valid_d    = valid_q;
    runnable_d = runnable_q;
    written_d  = written_q;
    running_d  = running_q;
    if (ram_we) begin
      written_d[ram_waddr] = 1'b1;
    end
    if (ctrl_i.item_wr && idx_ok) begin
      valid_d[item_addr]    = req_q.entry_valid;
      runnable_d[item_addr] = req_q.entry_runnable;
    end
    if (ctrl_i.commit) begin
      running_d = best_idx_q;
    end
  end

  // sweep pointer, read pipeline and best tracking
  always_comb begin
    sp_d         = sp_q;
    issue_en_d   = issue_en_q;
    pipe_vld_d   = pipe_vld_q;
    pipe_idx_d   = pipe_idx_q;
    pass_d       = pass_q;
    best_found_d = best_found_q;
    best_cnt_d   = best_cnt_q;
    best_idx_d   = best_idx_q;
    if (ctrl_i.sweep_start) begin
      sp_d         = LAST_SLOT;
      issue_en_d   = 1'b1;
      pipe_vld_d   = 1'b0;
      pass_d       = ctrl_i.sweep_pass1;
      best_found_d = 1'b0;
      best_cnt_d   = 8'd0;
      best_idx_d   = '0;
    end else if (ctrl_i.sweep_run) begin
      pipe_vld_d = issue_en_q;
      pipe_idx_d = sp_q;
      if (issue_en_q) begin
        if (sp_q == FIRST_SCANNED) begin
          issue_en_d = 1'b0;
        end else begin
          sp_d = sp_q - FIRST_SCANNED;
        end
      end
      if (better) begin
        best_found_d = 1'b1;
        best_cnt_d   = cand_cnt;
        best_idx_d   = pipe_idx_q;
      end
    end
  end

  // result hold and output register
  always_comb begin
    res_d = res_q;
    if (ctrl_i.cap) begin
      res_d = '0;
    end
    if (ctrl_i.rd_cap && idx_ok) begin
      res_d.read_valid        = valid_q[item_addr];
      res_d.read_runnable     = runnable_q[item_addr];
      res_d.read_priority     = item_ent.prio;
      res_d.read_counter      = item_ent.counter;
      res_d.read_user_ticks   = item_ent.user_ticks;
      res_d.read_kernel_ticks = item_ent.kernel_ticks;
    end
    if (ctrl_i.commit) begin
      res_d.switched = 1'b1;
    end
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    if (ctrl_i.load_out) begin
      out_d              = res_q;
      out_d.current_task = 6'(running_q);
      out_valid_d        = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q    <= '0;
      valid_q      <= TASK_SLOTS'(1);
      runnable_q   <= TASK_SLOTS'(1);
      written_q    <= '0;
      issue_en_q   <= 1'b0;
      pipe_vld_q   <= 1'b0;
      pass_q       <= 1'b0;
      best_found_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      running_q    <= running_d;
      valid_q      <= valid_d;
      runnable_q   <= runnable_d;
      written_q    <= written_d;
      issue_en_q   <= issue_en_d;
      pipe_vld_q   <= pipe_vld_d;
      pass_q       <= pass_d;
      best_found_q <= best_found_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ctrl_i.cap) begin
      req_q <= in_payload_i;
    end
    sp_q       <= sp_d;
    pipe_idx_q <= pipe_idx_d;
    best_cnt_q <= best_cnt_d;
    best_idx_q <= best_idx_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

  // status to the controller
  always_comb begin
    stat_o.cmd        = cmd;
    stat_o.sweep_done = !issue_en_q && !pipe_vld_q;
    stat_o.zero_best  = best_found_q && (best_cnt_q == 8'd0);
    stat_o.tick_sched = req_q.user_mode && (item_ent.counter <= 8'd1);
    stat_o.out_free   = !out_valid_q || out_ready_i;
  end

  assign out_payload_o = out_q;
  assign out_valid_o   = out_valid_q;
endmodule
